>>> rtl/lsi_pkg.sv
// ---------------------------------------------------------------------------
// lsi_pkg: shared types and constants for the 2D segment intersection unit
// Widths of coordinates, cross products, the quotient and the cell payload.
// ---------------------------------------------------------------------------
package lsi_pkg;

  localparam int CoordWidth = 16;
  localparam int FracBits   = 8;
  localparam int OutWidth   = 32;
  localparam int DiffWidth  = CoordWidth + 1;
  localparam int CrossWidth = 2 * DiffWidth + 1;
  localparam int ProdWidth  = CrossWidth + DiffWidth;
  localparam int DvdWidth   = ProdWidth + FracBits;
  localparam int DivWidth   = CrossWidth;
  localparam int QuoWidth   = DvdWidth;
  localparam int MagCapLog  = 40;
  localparam int SumWidth   = 44;
  localparam int CfgAddrWidth = 2;
  localparam logic [CfgAddrWidth-1:0] RegSegmentMode = '0;

  typedef struct packed {
    logic signed [CoordWidth-1:0] a_start_x;
    logic signed [CoordWidth-1:0] a_start_y;
    logic signed [CoordWidth-1:0] a_end_x;
    logic signed [CoordWidth-1:0] a_end_y;
    logic signed [CoordWidth-1:0] b_start_x;
    logic signed [CoordWidth-1:0] b_start_y;
    logic signed [CoordWidth-1:0] b_end_x;
    logic signed [CoordWidth-1:0] b_end_y;
  } in_item_t;

  typedef struct packed {
    logic                         hit;
    logic                         clipped;
    logic signed [OutWidth-1:0]   hit_x;
    logic signed [OutWidth-1:0]   hit_y;
  } out_item_t;

  // One lane of the restoring division, carried cell to cell.
  typedef struct packed {
    logic [DvdWidth-1:0] dvd;
    logic [DvdWidth:0]   rem;
    logic [QuoWidth-1:0] quo;
    logic                neg;
    logic signed [CoordWidth-1:0] base;
  } lane_t;

  // What a division cell carries besides its two lanes.
  typedef struct packed {
    logic                vld;
    logic                hit;
    logic [DivWidth-1:0] dmag;
  } ctl_t;

endpackage

>>> rtl/lsi_if.sv
// ---------------------------------------------------------------------------
// lsi_if: valid/ready channel
// Carries one payload item per transfer.
// ---------------------------------------------------------------------------
interface lsi_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/lsi_front.sv
// ---------------------------------------------------------------------------
// lsi_front: cross products and hit test
// Two register stages: products, then cross sums, bound test and magnitudes.
// ---------------------------------------------------------------------------
module lsi_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   seg_mode,
  input  logic                   in_vld,
  input  lsi_pkg::in_item_t      in_item,
  output lsi_pkg::ctl_t          ctl_o,
  output lsi_pkg::lane_t         lane_x_o,
  output lsi_pkg::lane_t         lane_y_o
);
  localparam int DW = lsi_pkg::DiffWidth;
  localparam int CW = lsi_pkg::CrossWidth;
  localparam int PW = lsi_pkg::ProdWidth;

  logic signed [DW-1:0] ax, ay, bx, by, wx, wy;
  logic signed [2*DW-1:0] p_axby_r, p_aybx_r, p_wxby_r, p_wybx_r, p_wxay_r, p_wyax_r;
  logic signed [DW-1:0] ax_r, ay_r;
  logic signed [lsi_pkg::CoordWidth-1:0] x1_r, y1_r;
  logic v1_r;

  assign ax = DW'(in_item.a_end_x) - DW'(in_item.a_start_x);
  assign ay = DW'(in_item.a_end_y) - DW'(in_item.a_start_y);
  assign bx = DW'(in_item.b_end_x) - DW'(in_item.b_start_x);
  assign by = DW'(in_item.b_end_y) - DW'(in_item.b_start_y);
  assign wx = DW'(in_item.b_start_x) - DW'(in_item.a_start_x);
  assign wy = DW'(in_item.b_start_y) - DW'(in_item.a_start_y);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
    end
    if (en) begin
      p_axby_r <= ax * by;
      p_aybx_r <= ay * bx;
      p_wxby_r <= wx * by;
      p_wybx_r <= wy * bx;
      p_wxay_r <= wx * ay;
      p_wyax_r <= wy * ax;
      ax_r <= ax;
      ay_r <= ay;
      x1_r <= in_item.a_start_x;
      y1_r <= in_item.a_start_y;
    end
  end

  logic signed [CW-1:0] den, tn, un;
  logic in_t, in_u, hit;
  logic [CW-1:0] dmag, tmag;
  logic [DW-1:0] axmag, aymag;

  assign den = CW'(p_axby_r) - CW'(p_aybx_r);
  assign tn  = CW'(p_wxby_r) - CW'(p_wybx_r);
  assign un  = CW'(p_wxay_r) - CW'(p_wyax_r);
  assign in_t = den[CW-1] ? (tn <= 0 && tn >= den) : (tn >= 0 && tn <= den);
  assign in_u = den[CW-1] ? (un <= 0 && un >= den) : (un >= 0 && un <= den);
  assign hit  = (den != 0) && (!seg_mode || (in_t && in_u));
  assign dmag = den[CW-1] ? -den : den;
  assign tmag = tn[CW-1] ? -tn : tn;
  assign axmag = ax_r[DW-1] ? -ax_r : ax_r;
  assign aymag = ay_r[DW-1] ? -ay_r : ay_r;

  // Second stage registers the magnitudes; the product runs here on
  // 35x17 bits, one multiplier per lane.
  logic [CW-1:0] tmag_r;
  logic [DW-1:0] axmag_r, aymag_r;
  logic negx_r, negy_r;
  lsi_pkg::ctl_t c2_r;
  logic signed [lsi_pkg::CoordWidth-1:0] x2_r, y2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c2_r.vld <= 1'b0;
    end else if (en) begin
      c2_r.vld <= v1_r;
    end
    if (en) begin
      c2_r.hit  <= hit;
      c2_r.dmag <= dmag;
      tmag_r  <= tmag;
      axmag_r <= axmag;
      aymag_r <= aymag;
      negx_r  <= (tn[CW-1] ^ ax_r[DW-1] ^ den[CW-1]) && tn != 0 && ax_r != 0;
      negy_r  <= (tn[CW-1] ^ ay_r[DW-1] ^ den[CW-1]) && tn != 0 && ay_r != 0;
      x2_r <= x1_r;
      y2_r <= y1_r;
    end
  end

  logic [PW-1:0] prod_x, prod_y;
  assign prod_x = PW'(tmag_r) * PW'(axmag_r);
  assign prod_y = PW'(tmag_r) * PW'(aymag_r);

  assign ctl_o = c2_r;
  always_comb begin
    lane_x_o      = '0;
    lane_x_o.dvd  = {prod_x, {lsi_pkg::FracBits{1'b0}}};
    lane_x_o.neg  = negx_r;
    lane_x_o.base = x2_r;
    lane_y_o      = '0;
    lane_y_o.dvd  = {prod_y, {lsi_pkg::FracBits{1'b0}}};
    lane_y_o.neg  = negy_r;
    lane_y_o.base = y2_r;
  end
endmodule

>>> rtl/lsi_div_cell.sv
// ---------------------------------------------------------------------------
// lsi_div_cell: one restoring division step for both lanes
// Shift in one dividend bit, subtract the divisor if it fits, pass on.
// ---------------------------------------------------------------------------
module lsi_div_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  lsi_pkg::ctl_t  ctl_i,
  input  lsi_pkg::lane_t lane_x_i,
  input  lsi_pkg::lane_t lane_y_i,
  output lsi_pkg::ctl_t  ctl_o,
  output lsi_pkg::lane_t lane_x_o,
  output lsi_pkg::lane_t lane_y_o
);
  localparam int DV = lsi_pkg::DvdWidth;

  function automatic lsi_pkg::lane_t step(lsi_pkg::lane_t l,
                                          logic [lsi_pkg::DivWidth-1:0] d);
    lsi_pkg::lane_t o;
    logic [DV:0] r;
    o = l;
    r = {l.rem[DV-1:0], l.dvd[DV-1]};
    o.dvd = {l.dvd[DV-2:0], 1'b0};
    if (r >= (DV+1)'(d)) begin
      o.rem = r - (DV+1)'(d);
      o.quo = {l.quo[lsi_pkg::QuoWidth-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {l.quo[lsi_pkg::QuoWidth-2:0], 1'b0};
    end
    return o;
  endfunction

  lsi_pkg::ctl_t  ctl_r;
  lsi_pkg::lane_t lx_r, ly_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r.vld <= 1'b0;
    end else if (en) begin
      ctl_r.vld <= ctl_i.vld;
    end
    if (en) begin
      ctl_r.hit  <= ctl_i.hit;
      ctl_r.dmag <= ctl_i.dmag;
      lx_r <= step(lane_x_i, ctl_i.dmag);
      ly_r <= step(lane_y_i, ctl_i.dmag);
    end
  end

  assign ctl_o    = ctl_r;
  assign lane_x_o = lx_r;
  assign lane_y_o = ly_r;
endmodule

>>> rtl/line_segment_intersect_2d_unit.sv
// Throughput: one item per cycle unless the output stalls; the 60-cell
//   restoring divider chain (one quotient bit per cell) holds up to 60
//   items in flight.
// The whole pipe advances together and holds while the output register is
//   full and not taken. rst_n (synchronous, active low) clears all valid
//   bits and sets segment_mode to 1.
// ---------------------------------------------------------------------------
// line_segment_intersect_2d_unit: 2D segment/line intersection
// Cross products, exact bound test, then floor(t*d*2^F) through a divider
// chain, and a final saturating add of the base coordinate.
// ---------------------------------------------------------------------------
module line_segment_intersect_2d_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  lsi_if.sink                               in_ch,
  lsi_if.source                             out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [lsi_pkg::CfgAddrWidth-1:0]  cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  localparam int NCell = lsi_pkg::DvdWidth;

  // Configuration register
  logic seg_mode_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_mode_r <= 1'b1;
    end else if (cfg_psel && cfg_penable && cfg_pwrite &&
                 cfg_paddr == lsi_pkg::RegSegmentMode) begin
      seg_mode_r <= cfg_pwdata[0];
    end
  end
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == lsi_pkg::RegSegmentMode) ? {31'd0, seg_mode_r} : '0;

  // Advance the pipe unless a finished result waits untaken.
  logic out_vld_r, en;
  assign en = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  lsi_pkg::ctl_t  ctl [NCell+1];
  lsi_pkg::lane_t lx  [NCell+1];
  lsi_pkg::lane_t ly  [NCell+1];

  lsi_front u_front (
    .clk, .rst_n, .en,
    .seg_mode (seg_mode_r),
    .in_vld   (in_ch.valid),
    .in_item  (in_ch.data),
    .ctl_o    (ctl[0]),
    .lane_x_o (lx[0]),
    .lane_y_o (ly[0])
  );

  for (genvar g = 0; g < NCell; g++) begin : g_cell
    lsi_div_cell u_cell (
      .clk, .rst_n, .en,
      .ctl_i (ctl[g]),   .lane_x_i (lx[g]),   .lane_y_i (ly[g]),
      .ctl_o (ctl[g+1]), .lane_x_o (lx[g+1]), .lane_y_o (ly[g+1])
    );
  end

  // Cap the magnitude, round toward minus infinity, add base, saturate.
  function automatic logic [lsi_pkg::OutWidth:0] finish(lsi_pkg::lane_t l);
    logic [lsi_pkg::SumWidth-1:0] mag, sum;
    logic [lsi_pkg::OutWidth:0] res;
    logic cap;
    cap = (l.quo >> lsi_pkg::MagCapLog) != 0;
    mag = cap ? (lsi_pkg::SumWidth)'(64'd1 << lsi_pkg::MagCapLog)
              : lsi_pkg::SumWidth'(l.quo);
    if (l.neg && l.rem != 0) mag = mag + 1'b1;
    if (l.neg) mag = -mag;
    sum = mag + (lsi_pkg::SumWidth'(signed'(l.base)) << lsi_pkg::FracBits);
    // Upper bits must all copy the sign bit, else the sum is out of range.
    if (!sum[lsi_pkg::SumWidth-1] && (|sum[lsi_pkg::SumWidth-2:lsi_pkg::OutWidth-1]))
      res = {1'b1, 1'b0, {(lsi_pkg::OutWidth-1){1'b1}}};
    else if (sum[lsi_pkg::SumWidth-1] && !(&sum[lsi_pkg::SumWidth-2:lsi_pkg::OutWidth-1]))
      res = {1'b1, 1'b1, {(lsi_pkg::OutWidth-1){1'b0}}};
    else
      res = {1'b0, sum[lsi_pkg::OutWidth-1:0]};
    return res;
  endfunction

  logic [lsi_pkg::OutWidth:0] fx, fy;
  assign fx = finish(lx[NCell]);
  assign fy = finish(ly[NCell]);

  lsi_pkg::out_item_t out_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= ctl[NCell].vld;
    end
    if (en) begin
      if (ctl[NCell].hit) begin
        out_r.hit     <= 1'b1;
        out_r.clipped <= fx[lsi_pkg::OutWidth] | fy[lsi_pkg::OutWidth];
        out_r.hit_x   <= fx[lsi_pkg::OutWidth-1:0];
        out_r.hit_y   <= fy[lsi_pkg::OutWidth-1:0];
      end else begin
        out_r <= '0;
      end
    end
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;
endmodule

>>> rtl/lsi_checker.sv
// ---------------------------------------------------------------------------
// lsi_checker: port-level checks for the intersection unit
// Handshake and result consistency.
// ---------------------------------------------------------------------------
module lsi_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input lsi_pkg::out_item_t out_data,
  input logic               cfg_pready
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.hit |-> !out_data.clipped && out_data.hit_x == 0 &&
    out_data.hit_y == 0)
    else $error("miss with nonzero fields");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");
  a_pready: assert property (@(posedge clk) cfg_pready)
    else $error("pready low");
endmodule

bind line_segment_intersect_2d_unit lsi_checker u_lsi_checker (
  .clk, .rst_n,
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data),
  .cfg_pready
);

>>> tb/tb_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: self-checking bench for line_segment_intersect_2d_unit
// Drives segment pairs over the valid/ready input channel and checks every
// result against a built-in integer predictor in both segment and line mode,
// with random idling on both channels.
// ---------------------------------------------------------------------------
module tb_top;

  // Expected intersection results, oldest first, and the predictor that
  // fills them.
  class hit_scoreboard;
    lsi_pkg::out_item_t pending[$];
    int        mismatches;

    // floor(base*2^F + n*dir*2^F/den), magnitude capped, then saturated.
    function logic signed [lsi_pkg::OutWidth-1:0] fixed_coord(longint base, longint n,
                                                              longint dir, longint den,
                                                              inout bit clip);
      longint prod, pmag, dmag, quo, rem, v;
      bit neg;
      prod = n * dir;
      neg  = (prod < 0) != (den < 0);
      if (prod == 0) neg = 0;
      pmag = (prod < 0 ? -prod : prod) <<< lsi_pkg::FracBits;
      dmag = den < 0 ? -den : den;
      quo  = pmag / dmag;
      rem  = pmag % dmag;
      if (quo > (64'sd1 <<< lsi_pkg::MagCapLog)) quo = 64'sd1 <<< lsi_pkg::MagCapLog;
      if (neg && rem != 0) quo++;
      v = base * (64'sd1 <<< lsi_pkg::FracBits) + (neg ? -quo : quo);
      if (v > 64'sd2147483647) begin
        v = 64'sd2147483647;
        clip = 1;
      end else if (v < -64'sd2147483648) begin
        v = -64'sd2147483648;
        clip = 1;
      end
      return v[lsi_pkg::OutWidth-1:0];
    endfunction

    function bit in_unit(longint num, longint den);
      if (den > 0) return num >= 0 && num <= den;
      return num <= 0 && num >= den;
    endfunction

    function void note_segments(lsi_pkg::in_item_t s, bit seg_mode);
      longint ax, ay, bx, by, wx, wy, den, tn, un;
      lsi_pkg::out_item_t r;
      bit clip;
      ax = longint'(s.a_end_x) - longint'(s.a_start_x);
      ay = longint'(s.a_end_y) - longint'(s.a_start_y);
      bx = longint'(s.b_end_x) - longint'(s.b_start_x);
      by = longint'(s.b_end_y) - longint'(s.b_start_y);
      wx = longint'(s.b_start_x) - longint'(s.a_start_x);
      wy = longint'(s.b_start_y) - longint'(s.a_start_y);
      den = ax * by - ay * bx;
      tn  = wx * by - wy * bx;
      un  = wx * ay - wy * ax;
      r = '0;
      clip = 0;
      if (den != 0 && (!seg_mode || (in_unit(tn, den) && in_unit(un, den)))) begin
        r.hit_x   = fixed_coord(longint'(s.a_start_x), tn, ax, den, clip);
        r.hit_y   = fixed_coord(longint'(s.a_start_y), tn, ay, den, clip);
        r.hit     = 1;
        r.clipped = clip;
      end
      pending.push_back(r);
    endfunction

    function void check_result(lsi_pkg::out_item_t got);
      lsi_pkg::out_item_t exp;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      exp = pending.pop_front();
      if (got.hit !== exp.hit || got.clipped !== exp.clipped ||
          got.hit_x !== exp.hit_x || got.hit_y !== exp.hit_y) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected hit=%0d clipped=%0d x=%0d y=%0d, ",
                    "got hit=%0d clipped=%0d x=%0d y=%0d"},
                   exp.hit, exp.clipped, exp.hit_x, exp.hit_y,
                   got.hit, got.clipped, got.hit_x, got.hit_y);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [lsi_pkg::CfgAddrWidth-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  lsi_if #(.T(lsi_pkg::in_item_t))  in_ch ();
  lsi_if #(.T(lsi_pkg::out_item_t)) out_ch ();

  line_segment_intersect_2d_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  localparam int IdleLimit  = 5000;
  localparam int DrainWait  = 80;

  hit_scoreboard sb = new();
  bit  seg_mode = 1;     // mirror of the segment_mode register
  bit  no_idle  = 0;     // suppress random gaps on both sides
  int  quiet_cycles = 0;

  always #2 clk = ~clk;

  initial begin
    in_ch.valid  = 0;
    in_ch.data   = '0;
    out_ch.ready = 0;
  end

  // Random back-pressure on the result side.
  always @(posedge clk) begin
    out_ch.ready <= no_idle || ($urandom_range(99) >= 35);
  end

  // Check every result transfer; count cycles without any transfer.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IdleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic cfg_write(logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= lsi_pkg::RegSegmentMode; cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    seg_mode = value[0];
  endtask

  // Read back the register and compare in the access phase.
  task automatic cfg_check;
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 0; cfg_penable <= 0;
    cfg_paddr <= lsi_pkg::RegSegmentMode;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    if (cfg_prdata[0] !== seg_mode) begin
      sb.mismatches++;
      if (sb.mismatches <= 10)
        $display("segment_mode readback: expected %0d, got %0d", seg_mode, cfg_prdata[0]);
    end
    cfg_psel <= 0; cfg_penable <= 0;
  endtask

  // Drop valid, hold until every expected result has come, then let the
  // pipe drain.
  task automatic drain;
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  // Present one pair of segments, hold until the transfer, then maybe idle.
  task automatic send(lsi_pkg::in_item_t s);
    in_ch.valid <= 1;
    in_ch.data  <= s;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_segments(s, seg_mode);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_ch.valid <= 0;
      @(posedge clk);
    end
  endtask

  task automatic send_xy(int ax0, int ay0, int ax1, int ay1,
                         int bx0, int by0, int bx1, int by1);
    lsi_pkg::in_item_t s;
    s = {16'(ax0), 16'(ay0), 16'(ax1), 16'(ay1),
         16'(bx0), 16'(by0), 16'(bx1), 16'(by1)};
    send(s);
  endtask

  function automatic int rnd_coord(int span);
    return int'($urandom_range(0, 2 * span - 1)) - span;
  endfunction

  // Mix full-range noise, small crossing-prone boxes and parallel pairs.
  task automatic send_random(int count);
    lsi_pkg::in_item_t s;
    int kind, dx, dy;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      if (kind < 3) begin
        s = {$urandom, $urandom, $urandom, $urandom};
      end else if (kind < 8) begin
        s = {16'(rnd_coord(64)), 16'(rnd_coord(64)), 16'(rnd_coord(64)),
             16'(rnd_coord(64)), 16'(rnd_coord(64)), 16'(rnd_coord(64)),
             16'(rnd_coord(64)), 16'(rnd_coord(64))};
      end else begin
        s = {$urandom, $urandom, $urandom, $urandom};
        dx = rnd_coord(100);
        dy = rnd_coord(100);
        s.b_start_x = s.a_start_x + 16'(dx);
        s.b_start_y = s.a_start_y + 16'(dy);
        s.b_end_x   = s.a_end_x + 16'(dx);
        s.b_end_y   = s.a_end_y + 16'(dy);
      end
      send(s);
    end
  endtask

  task automatic send_directed;
    send_xy(0, 0, 10, 10, 0, 10, 10, 0);               // plain crossing
    send_xy(-5, 3, 7, -2, 1, -9, 2, 11);               // fractional point
    send_xy(0, 0, 10, 0, 0, 5, 10, 5);                 // parallel
    send_xy(0, 0, 10, 10, 2, 2, 20, 20);               // collinear overlap
    send_xy(3, 3, 3, 3, 0, 0, 9, 9);                   // zero-length segment
    send_xy(0, 0, 10, 0, 10, -5, 10, 5);               // touch at end of A
    send_xy(0, 0, 10, 0, 4, 0, 4, 7);                  // touch at start of B
    send_xy(0, 0, 10, 0, 11, -5, 11, 5);               // just past the end
    send_xy(0, 0, 3, 0, 1, 7, 2, -7);                  // crossing at x = 1.5, exact quotient
    send_xy(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_xy(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    send_xy(-32768, 0, 32767, 0, 0, -32768, 1, 32767);
    send_xy(0, 0, 1, 0, -32768, 32767, 32767, 32766); // far point, clips in line mode
    send_xy(0, 0, 1, 0, 32767, -32768, -32768, -32767);
    send_xy(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_xy(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    cfg_check;                       // reset value of segment_mode

    send_directed;
    drain;
    cfg_write(0);
    cfg_check;
    send_directed;
    send_random(260);
    drain;                           // sender waits out the whole pipe

    cfg_write(1);
    cfg_check;
    send_random(120);
    no_idle = 1;                     // long stretch at full rate
    send_random(150);
    no_idle = 0;
    send_random(130);
    drain;

    cfg_write(0);
    send_random(140);
    drain;
    cfg_write(1);
    cfg_check;

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/lsi_pkg.sv
rtl/lsi_if.sv
rtl/lsi_front.sv
rtl/lsi_div_cell.sv
rtl/line_segment_intersect_2d_unit.sv
rtl/lsi_checker.sv
tb/tb_top.sv
